@@ design/log_odds_occupancy_cell_updater_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the log-odds occupancy cell updater
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef LOG_ODDS_OCCUPANCY_CELL_UPDATER_TOP_MACROS_SVH
`define LOG_ODDS_OCCUPANCY_CELL_UPDATER_TOP_MACROS_SVH

// Same-cycle implication
`define LOCU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LOCU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/locu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// locu_pkg
// Types and constants shared by the occupancy cell updater modules.
// ----------------------------------------------------------------------------
package locu_pkg;

  localparam int CfgIdxW = 3;

  typedef enum logic [1:0] {
    MODE_OBSERVE = 2'd0,
    MODE_APPLY   = 2'd1,
    MODE_RESET   = 2'd2,
    MODE_QUERY   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CLASS_UNKNOWN  = 2'd0,
    CLASS_FREE     = 2'd1,
    CLASS_OCCUPIED = 2'd2
  } class_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HIT_STEP  = 3'd0,
    CFG_MISS_STEP = 3'd1,
    CFG_CLAMP_MAX = 3'd2,
    CFG_CLAMP_MIN = 3'd3,
    CFG_OCC_THR   = 3'd4,
    CFG_FREE_THR  = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QREAD,
    ST_CREAD,
    ST_CALC,
    ST_DONE
  } state_e;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] cell_index;
    logic        is_hit;
  } in_t;

  typedef struct packed {
    logic [15:0]        cell_id;
    logic signed [15:0] cell_log_odds;
    class_e             class_before;
    class_e             class_after;
    logic               class_changed;
    logic               queue_was_empty;
    logic               count_saturated;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic empty_result;
    logic oor_result;
    logic q_read;
    logic c_read_in;
    logic c_read_q;
    logic simple_finish;
    logic mul;
    logic apply_finish;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_apply;
    logic in_oor;
    logic queue_empty;
    logic mode_apply_q;
    logic clear_last;
    logic out_free;
  } status_t;

endpackage

@@ design/log_odds_occupancy_cell_updater_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_odds_occupancy_cell_updater_top
// Log-odds occupancy grid cell updater with observe/apply/reset/query modes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one command beat:
//   observe, apply next pending cell, reset cell or query cell.
//   Each command yields exactly one result beat on the output channel
//   (out_valid_o / out_stall_i / out_data_o).
//   Config registers are written through cfg_valid_i / cfg_ready_o; the user
//   must write them only while idle, which the block does not enforce;
//   ready is always high. Steps from accept to result valid: empty-queue or
//   out-of-range commands go straight to the output load; observe/reset/query
//   read the cell RAM, then load the output; apply reads the queue RAM, then
//   the cell RAM, then multiplies, adds/clamps and loads the output. Items
//   pass one at a time: the next command is taken only once the sequencer
//   is back in idle. After reset, a clearing pass zeroes all CELL_COUNT
//   cell RAM entries, one entry a cycle, with in_stall_o high.
//   A stalled result sits in the output register; the next item is accepted
//   meanwhile and its result waits until the output register frees.
// ----------------------------------------------------------------------------
module log_odds_occupancy_cell_updater_top import locu_pkg::*; #(
  parameter int CELL_COUNT    = 65536,
  parameter int COUNTER_BITS  = 8,
  parameter int LOG_ODDS_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  cmd_t    cmd;
  status_t st;

  assign cfg_ready_o = 1'b1;

  locu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  locu_dp #(
    .CELL_COUNT    (CELL_COUNT),
    .COUNTER_BITS  (COUNTER_BITS),
    .LOG_ODDS_BITS (LOG_ODDS_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cfg_write_i (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule

@@ design/locu_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// locu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module locu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/locu_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// locu_ctrl
// Sequencer: clearing pass, then one item at a time through the datapath.
// ----------------------------------------------------------------------------
module locu_ctrl import locu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (st_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (st_i.in_apply) begin
            state_d = st_i.queue_empty ? ST_DONE : ST_QREAD;
          end else begin
            state_d = st_i.in_oor ? ST_DONE : ST_CREAD;
          end
        end
      end
      ST_QREAD: state_d = ST_CREAD;
      ST_CREAD: state_d = st_i.mode_apply_q ? ST_CALC : ST_DONE;
      ST_CALC:  state_d = ST_DONE;
      ST_DONE: begin
        if (st_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_CLEAR: cmd_o.clear_step = 1'b1;
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (st_i.in_apply) begin
            cmd_o.empty_result = st_i.queue_empty;
            cmd_o.q_read       = !st_i.queue_empty;
          end else begin
            cmd_o.oor_result = st_i.in_oor;
            cmd_o.c_read_in  = !st_i.in_oor;
          end
        end
      end
      ST_QREAD: cmd_o.c_read_q = 1'b1;
      ST_CREAD: begin
        cmd_o.mul           = st_i.mode_apply_q;
        cmd_o.simple_finish = !st_i.mode_apply_q;
      end
      ST_CALC: cmd_o.apply_finish = 1'b1;
      ST_DONE: cmd_o.load_out = st_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ design/locu_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// locu_dp
// Datapath: config registers, cell and queue RAMs, update arithmetic, output.
// ----------------------------------------------------------------------------
module locu_dp import locu_pkg::*; #(
  parameter int CELL_COUNT    = 65536,
  parameter int COUNTER_BITS  = 8,
  parameter int LOG_ODDS_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  in_t                in_data_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output out_t               out_data_o,
  input  logic               cfg_write_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  cmd_t               cmd_i,
  output status_t            st_o
);

  localparam int AW = $clog2(CELL_COUNT);
  localparam int CB = COUNTER_BITS;
  localparam int LB = LOG_ODDS_BITS;
  localparam int WW = LB + 2 * CB;
  localparam int PW = CB + 17;
  localparam int SW = ((LB > PW) ? LB : PW) + 1;
  localparam int FW = AW + 1;
  localparam longint FitHi = (longint'(1) << (LB - 1)) - 1;
  localparam longint FitLo = -FitHi - 1;

  // configuration registers
  logic [14:0]        hit_step_q;
  logic signed [15:0] miss_step_q, clamp_max_q, clamp_min_q, occ_thr_q, free_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_step_q  <= 15'd217;
      miss_step_q <= -16'sd104;
      clamp_max_q <= 16'sd1176;
      clamp_min_q <= -16'sd510;
      occ_thr_q   <= 16'sd355;
      free_thr_q  <= -16'sd217;
    end else if (cfg_write_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HIT_STEP:  hit_step_q  <= cfg_data_i[14:0];
        CFG_MISS_STEP: miss_step_q <= cfg_data_i;
        CFG_CLAMP_MAX: clamp_max_q <= cfg_data_i;
        CFG_CLAMP_MIN: clamp_min_q <= cfg_data_i;
        CFG_OCC_THR:   occ_thr_q   <= cfg_data_i;
        CFG_FREE_THR:  free_thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [SW-1:0] occ_w, free_w, cmax_w, cmin_w;
  assign occ_w  = SW'(occ_thr_q);
  assign free_w = SW'(free_thr_q);
  assign cmax_w = SW'(clamp_max_q);
  assign cmin_w = SW'(clamp_min_q);

  function automatic class_e classify(input logic signed [SW-1:0] v,
                                      input logic signed [SW-1:0] occ,
                                      input logic signed [SW-1:0] fre);
    class_e c;
    if (v > occ) c = CLASS_OCCUPIED;
    else if (v < fre) c = CLASS_FREE;
    else c = CLASS_UNKNOWN;
    return c;
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(CELL_COUNT - 1)) ? '0 : p + 1'b1;
  endfunction

  // item registers
  mode_e       mode_q;
  logic        hit_in_q;
  logic [AW-1:0] cell_q, clr_q, head_q, tail_q;
  logic [FW-1:0] fill_q;

  logic [AW+15:0] in_idx_wide, cell_wide;
  logic [AW-1:0]  in_idx_a;
  logic [31:0]    in_idx32;
  assign in_idx_wide = {{AW{1'b0}}, in_data_i.cell_index};
  assign in_idx_a    = in_idx_wide[AW-1:0];
  assign in_idx32    = {16'd0, in_data_i.cell_index};

  // RAMs
  logic          c_we, c_re;
  logic [AW-1:0] c_waddr, c_raddr;
  logic [WW-1:0] c_wdata, c_rdata;
  logic          q_we;
  logic [AW-1:0] q_rdata;

  locu_ram #(.WIDTH(WW), .DEPTH(CELL_COUNT)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .re_i    (c_re),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  locu_ram #(.WIDTH(AW), .DEPTH(CELL_COUNT)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (tail_q),
    .wdata_i (cell_q),
    .re_i    (cmd_i.q_read),
    .raddr_i (head_q),
    .rdata_o (q_rdata)
  );

  // fields of the cell word read back
  logic signed [LB-1:0] c_lo;
  logic [CB-1:0]        c_obs, c_hit, obs_n, hit_n;
  logic signed [SW-1:0] c_lo_w;
  logic                 obs_full, hit_full, push, sat;
  class_e               c_class;

  assign c_lo     = c_rdata[WW-1 -: LB];
  assign c_obs    = c_rdata[2*CB-1 -: CB];
  assign c_hit    = c_rdata[CB-1:0];
  assign c_lo_w   = SW'(c_lo);
  assign c_class  = classify(c_lo_w, occ_w, free_w);
  assign obs_full = (c_obs == {CB{1'b1}});
  assign hit_full = (c_hit == {CB{1'b1}});
  assign obs_n    = obs_full ? c_obs : c_obs + 1'b1;
  assign hit_n    = (hit_in_q && !hit_full) ? c_hit + 1'b1 : c_hit;
  assign sat      = obs_full | (hit_in_q & hit_full);
  assign push     = !obs_full && (c_obs == '0) && (fill_q < FW'(CELL_COUNT));
  assign q_we     = cmd_i.simple_finish && (mode_q == MODE_OBSERVE) && push;

  // apply arithmetic: product stage, then add/clamp stage
  logic signed [LB-1:0] lo_q;
  logic signed [PW-1:0] prod_q;
  logic                 hit_any_q;
  class_e               cb_q;
  logic signed [16:0]   mul_a;
  logic signed [CB:0]   mul_b;
  logic signed [SW-1:0] sum, clamped, sum_fit;

  assign mul_a = (c_hit != '0) ? $signed({2'b00, hit_step_q})
                               : $signed({miss_step_q[15], miss_step_q});
  assign mul_b = $signed({1'b0, (c_hit != '0) ? c_hit : c_obs});

  assign sum = SW'(lo_q) + SW'(prod_q);
  always_comb begin
    if (hit_any_q) clamped = (sum > cmax_w) ? cmax_w : sum;
    else clamped = (sum < cmin_w) ? cmin_w : sum;
    if (clamped > SW'(FitHi)) sum_fit = SW'(FitHi);
    else if (clamped < SW'(FitLo)) sum_fit = SW'(FitLo);
    else sum_fit = clamped;
  end

  assign cell_wide = {16'd0, cell_q};

  // cell RAM port control
  assign c_re    = cmd_i.c_read_in | cmd_i.c_read_q;
  assign c_raddr = cmd_i.c_read_q ? q_rdata : in_idx_a;
  assign c_we    = cmd_i.clear_step | cmd_i.apply_finish |
                   (cmd_i.simple_finish && mode_q != MODE_QUERY);
  assign c_waddr = cmd_i.clear_step ? clr_q : cell_q;
  always_comb begin
    if (cmd_i.clear_step) c_wdata = '0;
    else if (cmd_i.apply_finish) c_wdata = {sum_fit[LB-1:0], {2*CB{1'b0}}};
    else if (mode_q == MODE_OBSERVE) c_wdata = {c_lo, obs_n, hit_n};
    else c_wdata = {{LB{1'b0}}, c_obs, c_hit};
  end

  // result assembly
  out_t res_q, res_d;
  class_e ca;
  always_comb begin
    res_d = '0;
    ca    = CLASS_UNKNOWN;
    if (cmd_i.empty_result) begin
      res_d.queue_was_empty = 1'b1;
    end else if (cmd_i.oor_result) begin
      res_d.cell_id = in_data_i.cell_index;
    end else if (cmd_i.apply_finish) begin
      ca = classify(sum_fit, occ_w, free_w);
      res_d.cell_id       = cell_wide[15:0];
      res_d.cell_log_odds = sum_fit[15:0];
      res_d.class_before  = cb_q;
      res_d.class_after   = ca;
      res_d.class_changed = (cb_q != ca);
    end else begin
      res_d.cell_id      = cell_wide[15:0];
      res_d.class_before = c_class;
      case (mode_q)
        MODE_RESET: begin
          ca = classify('0, occ_w, free_w);
          res_d.cell_log_odds = '0;
          res_d.class_after   = ca;
          res_d.class_changed = (c_class != ca);
        end
        MODE_OBSERVE: begin
          res_d.cell_log_odds   = c_lo_w[15:0];
          res_d.class_after     = c_class;
          res_d.count_saturated = sat;
        end
        default: begin
          res_d.cell_log_odds = c_lo_w[15:0];
          res_d.class_after   = c_class;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q   <= in_data_i.mode;
      hit_in_q <= in_data_i.is_hit;
    end
    if (cmd_i.accept) cell_q <= in_idx_a;
    else if (cmd_i.c_read_q) cell_q <= q_rdata;
    if (cmd_i.mul) begin
      lo_q      <= c_lo;
      cb_q      <= c_class;
      hit_any_q <= (c_hit != '0);
      prod_q    <= PW'(mul_a) * PW'(mul_b);
    end
    if (cmd_i.empty_result || cmd_i.oor_result || cmd_i.apply_finish ||
        cmd_i.simple_finish) begin
      res_q <= res_d;
    end
    if (cmd_i.load_out) out_data_o <= res_q;
  end

  // control registers: clearing sweep, queue pointers, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.clear_step) clr_q <= ptr_inc(clr_q);
      if (cmd_i.q_read) begin
        head_q <= ptr_inc(head_q);
        fill_q <= fill_q - 1'b1;
      end else if (q_we) begin
        tail_q <= ptr_inc(tail_q);
        fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.load_out) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  // status to the controller
  assign st_o.in_apply     = (in_data_i.mode == MODE_APPLY);
  assign st_o.in_oor       = (in_idx32 >= 32'(CELL_COUNT));
  assign st_o.queue_empty  = (fill_q == '0);
  assign st_o.mode_apply_q = (mode_q == MODE_APPLY);
  assign st_o.clear_last   = (clr_q == AW'(CELL_COUNT - 1));
  assign st_o.out_free     = !out_valid_o || !out_stall_i;

endmodule

@@ design/locu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// locu_checker
// Port-level checks on the cell updater's result channel.
// ----------------------------------------------------------------------------
`include "log_odds_occupancy_cell_updater_top_macros.svh"

module locu_checker import locu_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // a stalled result beat stays up and unchanged
  `LOCU_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped")
  `LOCU_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_data_o), "result moved")

  // changed flag matches the class pair
  `LOCU_ASSERT_NOW(a_changed, out_valid_o, out_data_o.class_changed == (out_data_o.class_before != out_data_o.class_after), "class_changed wrong")

  // empty-queue beats carry a zero cell id and log-odds and no saturation flag
  `LOCU_ASSERT_NOW(a_empty, out_valid_o && out_data_o.queue_was_empty, out_data_o.cell_id == 16'd0 && out_data_o.cell_log_odds == 16'sd0 && !out_data_o.count_saturated, "empty beat not zero")

endmodule

bind log_odds_occupancy_cell_updater_top locu_checker u_locu_checker (.*);

@@ tb/tb_log_odds_occupancy_cell_updater_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_log_odds_occupancy_cell_updater_top
// Drives observe/apply/reset/query beats with random gaps and output stalls,
// predicts each result from a local model of the cell tables and queue, and
// checks every result beat field by field in order.
// ----------------------------------------------------------------------------
module tb_log_odds_occupancy_cell_updater_top;
  import locu_pkg::*;

  localparam int CELLS = 65536;
  localparam int CMAX = 255;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  int err_count = 0;
  int beats_in = 0;
  int beats_out = 0;
  bit hold_out = 1'b0;
  bit pressure_done = 1'b0;

  log_odds_occupancy_cell_updater_top dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // Cell update model and FIFO of expected result beats
  class cell_scoreboard;
    logic signed [15:0] odds [CELLS];
    logic [7:0] obs_cnt [CELLS];
    logic [7:0] hit_cnt [CELLS];
    logic [15:0] pend_q [$];
    out_t due_q [$];
    longint hit_step, miss_step, clamp_max, clamp_min, occ_thr, free_thr;

    function new();
      foreach (odds[i]) begin
        odds[i] = '0; obs_cnt[i] = '0; hit_cnt[i] = '0;
      end
      hit_step = 217; miss_step = -104; clamp_max = 1176;
      clamp_min = -510; occ_thr = 355; free_thr = -217;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] val);
      case (idx)
        CFG_HIT_STEP:  hit_step = longint'(val[14:0]);
        CFG_MISS_STEP: miss_step = longint'(signed'(val));
        CFG_CLAMP_MAX: clamp_max = longint'(signed'(val));
        CFG_CLAMP_MIN: clamp_min = longint'(signed'(val));
        CFG_OCC_THR:   occ_thr = longint'(signed'(val));
        CFG_FREE_THR:  free_thr = longint'(signed'(val));
        default: ;
      endcase
    endfunction

    function class_e classify(longint v);
      if (v > occ_thr) return CLASS_OCCUPIED;
      if (v < free_thr) return CLASS_FREE;
      return CLASS_UNKNOWN;
    endfunction

    function void note_input(in_t b);
      out_t r;
      longint v;
      int c;
      r = '0;
      if (b.mode == MODE_APPLY) begin
        if (pend_q.size() == 0) begin
          r.queue_was_empty = 1'b1;
        end else begin
          c = pend_q.pop_front();
          v = odds[c];
          r.class_before = classify(v);
          if (hit_cnt[c] > 0) begin
            v += hit_step * hit_cnt[c];
            if (v > clamp_max) v = clamp_max;
          end else begin
            v += miss_step * obs_cnt[c];
            if (v < clamp_min) v = clamp_min;
          end
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          odds[c] = v[15:0];
          hit_cnt[c] = '0;
          obs_cnt[c] = '0;
          r.cell_id = c[15:0];
          r.cell_log_odds = v[15:0];
          r.class_after = classify(v);
        end
      end else begin
        c = b.cell_index;
        v = odds[c];
        r.cell_id = b.cell_index;
        r.class_before = classify(v);
        r.class_after = r.class_before;
        r.cell_log_odds = odds[c];
        if (b.mode == MODE_OBSERVE) begin
          if (obs_cnt[c] >= CMAX) r.count_saturated = 1'b1;
          else begin
            obs_cnt[c]++;
            if (obs_cnt[c] == 1) pend_q = {pend_q, b.cell_index};
          end
          if (b.is_hit) begin
            if (hit_cnt[c] >= CMAX) r.count_saturated = 1'b1;
            else hit_cnt[c]++;
          end
        end else if (b.mode == MODE_RESET) begin
          odds[c] = '0;
          r.cell_log_odds = '0;
          r.class_after = classify(0);
        end
      end
      r.class_changed = (r.class_before != r.class_after);
      due_q = {due_q, r};
    endfunction

    task check_result(out_t got);
      out_t w;
      if (due_q.size() == 0) begin
        report_mismatch("unexpected result, cell_id", got.cell_id, -1);
        return;
      end
      w = due_q.pop_front();
      if (got.cell_id !== w.cell_id) report_mismatch("cell_id", got.cell_id, w.cell_id);
      if (got.cell_log_odds !== w.cell_log_odds)
        report_mismatch("cell_log_odds", got.cell_log_odds, w.cell_log_odds);
      if (got.class_before !== w.class_before)
        report_mismatch("class_before", got.class_before, w.class_before);
      if (got.class_after !== w.class_after)
        report_mismatch("class_after", got.class_after, w.class_after);
      if (got.class_changed !== w.class_changed)
        report_mismatch("class_changed", got.class_changed, w.class_changed);
      if (got.queue_was_empty !== w.queue_was_empty)
        report_mismatch("queue_was_empty", got.queue_was_empty, w.queue_was_empty);
      if (got.count_saturated !== w.count_saturated)
        report_mismatch("count_saturated", got.count_saturated, w.count_saturated);
    endtask
  endclass

  cell_scoreboard sb = new();

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one command beat, hold it until accepted
  task automatic send_cmd(input mode_e m, input logic [15:0] idx, input logic hit);
    in_t b;
    b.mode = m; b.cell_index = idx; b.is_hit = hit;
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(b);
    beats_in++;
  endtask

  task automatic idle_in(input int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // valid stays up across a burst of writes; write_all drops it at the end
  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
  endtask

  task automatic write_all(input logic [15:0] hs, ms, cmx, cmn, ot, ft);
    write_reg(CFG_HIT_STEP, hs);
    write_reg(CFG_MISS_STEP, ms);
    write_reg(CFG_CLAMP_MAX, cmx);
    write_reg(CFG_CLAMP_MIN, cmn);
    write_reg(CFG_OCC_THR, ot);
    write_reg(CFG_FREE_THR, ft);
    cfg_valid_i <= 1'b0;
  endtask

  // Random phase: a mix of observe, apply, query and reset, mostly on a small working set
  task automatic random_phase(input int n);
    int k;
    logic [15:0] base;
    logic [15:0] idx;
    mode_e m;
    base = 16'($urandom());
    for (k = 0; k < n; k++) begin
      idle_in(gap_len());
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: m = MODE_OBSERVE;
        5, 6, 7: m = MODE_APPLY;
        8: m = MODE_QUERY;
        default: m = MODE_RESET;
      endcase
      if ($urandom_range(0, 9) < 7) idx = 16'(base + $urandom_range(0, 15));
      else idx = 16'($urandom());
      send_cmd(m, idx, 1'($urandom_range(0, 1)));
    end
  endtask

  // Output side: random stalls, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_out) begin
        out_stall_i <= 1'b1;
        repeat (60) @(posedge clk_i);
        hold_out = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        n = gap_len();
        out_stall_i <= (n != 0);
        if (n > 1) repeat (n - 1) @(posedge clk_i);
      end
    end
  end

  // Result monitor
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        sb.check_result(out_data_o);
        beats_out++;
      end
    end
  end

  initial begin
    #400ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int k;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty queue, extremes, every mode, saturation
    send_cmd(MODE_APPLY, 16'h0000, 1'b0);
    send_cmd(MODE_QUERY, 16'hFFFF, 1'b1);
    send_cmd(MODE_OBSERVE, 16'h0000, 1'b1);
    send_cmd(MODE_OBSERVE, 16'hFFFF, 1'b0);
    send_cmd(MODE_OBSERVE, 16'hFFFF, 1'b0);
    send_cmd(MODE_APPLY, 16'h1234, 1'b1);
    send_cmd(MODE_APPLY, 16'h0000, 1'b0);
    send_cmd(MODE_QUERY, 16'h0000, 1'b0);
    send_cmd(MODE_RESET, 16'h0000, 1'b0);
    send_cmd(MODE_OBSERVE, 16'h0000, 1'b0);
    send_cmd(MODE_RESET, 16'h0000, 1'b1);
    send_cmd(MODE_APPLY, 16'h0000, 1'b0);
    send_cmd(MODE_APPLY, 16'h0000, 1'b0);
    drain();
    // counter saturation on one cell (long run)
    for (k = 0; k < 258; k++) send_cmd(MODE_OBSERVE, 16'h00AA, k[0] | (k > 200));
    send_cmd(MODE_APPLY, 16'h0, 1'b0);
    drain();

    // Default settings, with a long output hold-off at the start of the phase
    hold_out = 1'b1;
    random_phase(200);
    drain();

    write_all(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    random_phase(250);
    drain();
    write_all(16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    random_phase(200);
    drain();
    write_all(16'h0100, 16'hFF00, 16'h0400, 16'hFC00, 16'h0080, 16'hFF80);
    hold_out = 1'b1;
    random_phase(250);
    drain();
    write_all(16'($urandom()), 16'($urandom()), 16'($urandom()),
              16'($urandom()), 16'($urandom()), 16'($urandom()));
    random_phase(200);
    drain();
    write_all(217, 16'hFF98, 1176, 16'hFE02, 355, 16'hFF29);
    random_phase(250);
    // flush whatever is still pending
    for (k = 0; k < 40; k++) send_cmd(MODE_APPLY, 16'h0, 1'b0);
    drain();

    $display("Covered %0d command beats, %0d result beats, six register settings.",
             beats_in, beats_out);
    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/locu_pkg.sv
design/locu_ram.sv
design/locu_ctrl.sv
design/locu_dp.sv
design/log_odds_occupancy_cell_updater_top.sv
design/locu_checker.sv
tb/tb_log_odds_occupancy_cell_updater_top.sv
